[hdl/button_debounce_press_classifier_macros.svh]
// Assertion macros for the button debounce and press classifier.
// Included by the top level; expects clk and arst_n in scope.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define BDPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BDPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BDPC_ASSERT_NOW(label, ante, cons, msg)
`define BDPC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[hdl/bdpc_pkg.sv]
// Shared types, codes and functions of the button debounce and press classifier.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package bdpc_pkg;
	localparam int NUM_BUTTONS_DEF = 2;
	localparam int PIN_W = 2;
	localparam int CNT_W = 16;
	localparam int CLASS_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int IN_DATA_W = 8;
	localparam int OUT_DATA_W = 8;

	localparam logic [CLASS_W-1:0] CLS_RELEASED = 3'd0;
	localparam logic [CLASS_W-1:0] CLS_PRESS_FLANK = 3'd1;
	localparam logic [CLASS_W-1:0] CLS_PRESSED = 3'd2;
	localparam logic [CLASS_W-1:0] CLS_LONG_FLANK = 3'd3;
	localparam logic [CLASS_W-1:0] CLS_LONG_PRESSED = 3'd4;
	localparam logic [CLASS_W-1:0] CLS_RELEASE_FLANK = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_FILTER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd2;

	localparam logic [CNT_W-1:0] FILTER_RST = 16'd3;
	localparam logic [CNT_W-1:0] PRESS_RST = 16'd10;
	localparam logic [CNT_W-1:0] LONG_PRESS_RST = 16'd500;

	typedef struct packed {
		logic [CNT_W-1:0] filter_ticks;
		logic [CNT_W-1:0] press_ticks;
		logic [CNT_W-1:0] long_press_ticks;
	} thresholds_t;

	typedef struct packed {
		logic pressed;
		logic [CLASS_W-1:0] cls;
	} lane_result_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (&v) ? v : v + 1'b1;
	endfunction
endpackage
`default_nettype wire

[hdl/bdpc_lane.sv]
// One button lane: debounce filter, press timer and six-state press classifier.
// Depends on bdpc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bdpc_lane (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  advance,
	input  wire logic                  raw_pressed,
	input  wire bdpc_pkg::thresholds_t thr,
	output bdpc_pkg::lane_result_t     result
);
	import bdpc_pkg::*;

	logic               last_raw_q;
	logic [CNT_W-1:0]   stable_q;
	logic               deb_q;
	logic [CNT_W-1:0]   press_cnt_q;
	logic [CLASS_W-1:0] class_q;

	logic               last_raw_n;
	logic [CNT_W-1:0]   stable_n;
	logic               deb_n;
	logic [CNT_W-1:0]   press_cnt_n;
	logic [CLASS_W-1:0] class_n;
	logic               press_met;

	always_comb begin
		last_raw_n = raw_pressed;
		stable_n = (raw_pressed == last_raw_q) ? sat_inc(stable_q) : '0;
		deb_n = (stable_n >= thr.filter_ticks) ? raw_pressed : deb_q;
		press_cnt_n = deb_n ? sat_inc(press_cnt_q) : '0;
		press_met = deb_n && (press_cnt_n >= thr.press_ticks);
		case (class_q)
			CLS_RELEASED: begin
				class_n = press_met ? CLS_PRESS_FLANK : CLS_RELEASED;
			end
			CLS_PRESS_FLANK: begin
				class_n = deb_n ? CLS_PRESSED : CLS_RELEASE_FLANK;
			end
			CLS_PRESSED: begin
				if (!deb_n) begin
					class_n = CLS_RELEASE_FLANK;
				end else if (press_cnt_n >= thr.long_press_ticks) begin
					class_n = CLS_LONG_FLANK;
				end else begin
					class_n = CLS_PRESSED;
				end
			end
			CLS_LONG_FLANK, CLS_LONG_PRESSED: begin
				class_n = deb_n ? CLS_LONG_PRESSED : CLS_RELEASE_FLANK;
			end
			CLS_RELEASE_FLANK: begin
				class_n = press_met ? CLS_PRESS_FLANK : CLS_RELEASED;
			end
			default: begin
				class_n = CLS_RELEASED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q <= 1'b0;
			stable_q <= '0;
			deb_q <= 1'b0;
			press_cnt_q <= '0;
			class_q <= CLS_RELEASED;
		end else if (advance) begin
			last_raw_q <= last_raw_n;
			stable_q <= stable_n;
			deb_q <= deb_n;
			press_cnt_q <= press_cnt_n;
			class_q <= class_n;
		end
	end

	assign result.pressed = deb_n;
	assign result.cls = class_n;
endmodule
`default_nettype wire

[hdl/bdpc_merge.sv]
// Merging stage: gathers the lane results into one output item and holds it
// in the output register until taken. Depends on bdpc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bdpc_merge #(
	parameter int NUM_BUTTONS = bdpc_pkg::NUM_BUTTONS_DEF
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          load,
	input  wire bdpc_pkg::lane_result_t [NUM_BUTTONS-1:0]      lanes,
	input  wire logic                                          out_ready,
	output logic                                               out_valid,
	output logic [bdpc_pkg::OUT_DATA_W-1:0]                    out_data
);
	import bdpc_pkg::*;

	logic [PIN_W-1:0]   deb_bits;
	logic [CLASS_W-1:0] class0;
	logic [CLASS_W-1:0] class1;
	logic               valid_q;
	logic [OUT_DATA_W-1:0] data_q;

	always_comb begin
		for (int b = 0; b < PIN_W; b++) begin
			deb_bits[b] = (b < NUM_BUTTONS) ? lanes[b % NUM_BUTTONS].pressed : 1'b0;
		end
	end

	assign class0 = lanes[0].cls;

	generate
		if (NUM_BUTTONS > 1) begin : g_second
			assign class1 = lanes[1].cls;
		end else begin : g_no_second
			assign class1 = CLS_RELEASED;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= {class1, class0, deb_bits};
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;
endmodule
`default_nettype wire

[hdl/button_debounce_press_classifier.sv]
// Two-button debounce filter with press and long-press classifier.
// Latency: an accepted item's result is in the output register in the cycle after it.
// Throughput: one item per cycle unless m_axis_tready stalls; each lane steps per item.
// Reset: arst_n clears all lane state and loads the default thresholds 3, 10, 500.
// Depends on bdpc_pkg, bdpc_lane, bdpc_merge and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "button_debounce_press_classifier_macros.svh"
module button_debounce_press_classifier #(
	parameter int NUM_BUTTONS = bdpc_pkg::NUM_BUTTONS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// Fields from bit 0: pin_levels[1:0], zero padding.
	input  wire logic [bdpc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// Fields from bit 0: debounced_pressed[1:0], first_button_class[4:2],
	// second_button_class[7:5].
	output logic [bdpc_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [bdpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [bdpc_pkg::CNT_W-1:0]         cfg_data
);
	import bdpc_pkg::*;

	thresholds_t thr_q;
	lane_result_t [NUM_BUTTONS-1:0] lane_res;
	logic in_fire;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.filter_ticks <= FILTER_RST;
			thr_q.press_ticks <= PRESS_RST;
			thr_q.long_press_ticks <= LONG_PRESS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FILTER: begin
					thr_q.filter_ticks <= cfg_data;
				end
				CFG_PRESS: begin
					thr_q.press_ticks <= cfg_data;
				end
				CFG_LONG_PRESS: begin
					thr_q.long_press_ticks <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	generate
		for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
			logic raw_pressed;
			if (i < PIN_W) begin : g_pin
				assign raw_pressed = ~s_axis_tdata[i];
			end else begin : g_no_pin
				assign raw_pressed = 1'b0;
			end
			bdpc_lane u_lane (
				.clk         (clk),
				.arst_n      (arst_n),
				.advance     (in_fire),
				.raw_pressed (raw_pressed),
				.thr         (thr_q),
				.result      (lane_res[i])
			);
		end
	endgenerate

	bdpc_merge #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_fire),
		.lanes     (lane_res),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata)
	);

	`BDPC_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input stalled with empty output register")
	`BDPC_ASSERT_NEXT(a_result_follows, in_fire, m_axis_tvalid, "accepted item produced no result")
	`BDPC_ASSERT_NOW(a_released_class, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[4:2] == CLS_RELEASED || m_axis_tdata[4:2] == CLS_RELEASE_FLANK, "released button shows a pressed class")
endmodule
`default_nettype wire

[sim/debounce_monitor.sv]
// Watches the tick, result and register channels of the button debounce and press classifier.
// Predicts each result from its own copy of the lane state and compares it field by field.
// Depends on bdpc_pkg for widths, class codes, register indexes and reset thresholds.
`timescale 1ns / 1ps
module debounce_monitor
	import bdpc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CNT_W-1:0]      cfg_data,
	output int                         errors,
	output int                         pending
);
	localparam int LANES = 2;

	typedef struct packed {
		logic [CLASS_W-1:0] second_cls;
		logic [CLASS_W-1:0] first_cls;
		logic [1:0]         pressed;
	} tick_report_t;

	tick_report_t expected_reports[$];

	logic [CNT_W-1:0]   filter_thr;
	logic [CNT_W-1:0]   press_thr;
	logic [CNT_W-1:0]   long_thr;
	logic               raw_prev [LANES];
	logic [CNT_W-1:0]   stable_cnt [LANES];
	logic               held_pressed [LANES];
	logic [CNT_W-1:0]   press_cnt [LANES];
	logic [CLASS_W-1:0] lane_cls [LANES];

	function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic logic [CLASS_W-1:0] advance_class(input logic [CLASS_W-1:0] cls,
			input logic pressed, input logic [CNT_W-1:0] cnt);
		case (cls)
			CLS_RELEASED, CLS_RELEASE_FLANK: begin
				return (pressed && cnt >= press_thr) ? CLS_PRESS_FLANK : CLS_RELEASED;
			end
			CLS_PRESS_FLANK: begin
				return pressed ? CLS_PRESSED : CLS_RELEASE_FLANK;
			end
			CLS_PRESSED: begin
				if (!pressed)
					return CLS_RELEASE_FLANK;
				return (cnt >= long_thr) ? CLS_LONG_FLANK : CLS_PRESSED;
			end
			CLS_LONG_FLANK, CLS_LONG_PRESSED: begin
				return pressed ? CLS_LONG_PRESSED : CLS_RELEASE_FLANK;
			end
			default: begin
				return CLS_RELEASED;
			end
		endcase
	endfunction

	task automatic debounce_tick(input logic [PIN_W-1:0] pins, output tick_report_t rep);
		logic raw;
		rep = '0;
		for (int i = 0; i < LANES; i++) begin
			raw = ~pins[i];
			stable_cnt[i] = (raw == raw_prev[i]) ? count_up(stable_cnt[i]) : '0;
			if (stable_cnt[i] >= filter_thr)
				held_pressed[i] = raw;
			raw_prev[i] = raw;
			press_cnt[i] = held_pressed[i] ? count_up(press_cnt[i]) : '0;
			lane_cls[i] = advance_class(lane_cls[i], held_pressed[i], press_cnt[i]);
			rep.pressed[i] = held_pressed[i];
		end
		rep.first_cls = lane_cls[0];
		rep.second_cls = lane_cls[1];
	endtask

	always @(posedge clk or negedge arst_n) begin
		tick_report_t seen;
		tick_report_t want;
		if (!arst_n) begin
			filter_thr = FILTER_RST;
			press_thr = PRESS_RST;
			long_thr = LONG_PRESS_RST;
			for (int i = 0; i < LANES; i++) begin
				raw_prev[i] = 1'b0;
				stable_cnt[i] = '0;
				held_pressed[i] = 1'b0;
				press_cnt[i] = '0;
				lane_cls[i] = CLS_RELEASED;
			end
			expected_reports.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FILTER: filter_thr = cfg_data;
					CFG_PRESS: press_thr = cfg_data;
					CFG_LONG_PRESS: long_thr = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				seen = m_tdata[7:0];
				if (expected_reports.size() == 0) begin
					$display("%0t: result item %h arrived with nothing expected", $time, m_tdata);
					errors++;
				end else begin
					want = expected_reports.pop_front();
					if (seen.pressed !== want.pressed) begin
						$display("%0t: debounced_pressed expected %0d actual %0d",
							$time, want.pressed, seen.pressed);
						errors++;
					end
					if (seen.first_cls !== want.first_cls) begin
						$display("%0t: first_button_class expected %0d actual %0d",
							$time, want.first_cls, seen.first_cls);
						errors++;
					end
					if (seen.second_cls !== want.second_cls) begin
						$display("%0t: second_button_class expected %0d actual %0d",
							$time, want.second_cls, seen.second_cls);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				debounce_tick(s_tdata[PIN_W-1:0], want);
				expected_reports.push_back(want);
			end
			pending = expected_reports.size();
		end
	end
endmodule

[sim/testbench.sv]
// Top level of the button debounce and press classifier test: clock, reset and stimulus.
// Instantiates the block beside debounce_monitor, which predicts and compares every item.
// Depends on bdpc_pkg, button_debounce_press_classifier and debounce_monitor.
`timescale 1ns / 1ps
module testbench;
	import bdpc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [PIN_W-1:0] BOTH_UP = 2'b11;
	localparam logic [PIN_W-1:0] BOTH_DOWN = 2'b00;
	localparam logic [PIN_W-1:0] DIRECTED [25] = '{
		2'b11, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00,
		2'b10, 2'b10, 2'b10, 2'b11, 2'b11, 2'b11, 2'b01, 2'b01, 2'b01,
		2'b00, 2'b11, 2'b00, 2'b11, 2'b11, 2'b11
	};

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CNT_W-1:0]      cfg_data;
	int                    errors;
	int                    pending;
	bit                    quiet;
	int                    rx_stall;

	button_debounce_press_classifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	debounce_monitor monitor (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_axis_tvalid),
		.s_tready(s_axis_tready),
		.s_tdata(s_axis_tdata),
		.m_tvalid(m_axis_tvalid),
		.m_tready(m_axis_tready),
		.m_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending)
	);

	always #10 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(negedge clk) begin
		if (quiet) begin
			m_axis_tready <= 1'b1;
		end else if (rx_stall > 0) begin
			m_axis_tready <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else if ($urandom_range(0, 9) < 2) begin
			m_axis_tready <= 1'b0;
			rx_stall <= gap_len();
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_tick(input logic [PIN_W-1:0] pins);
		int g;
		g = quiet ? 0 : gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_axis_tdata <= {{(IN_DATA_W-PIN_W){1'b0}}, pins};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// Mostly held levels with optional contact bounce in front, the rest single noisy ticks.
	task automatic run_segments(input int count);
		int n;
		int hold;
		int noise;
		logic [PIN_W-1:0] target;
		logic [PIN_W-1:0] pins;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 9) < 3) begin
				pins = PIN_W'($urandom_range(0, 3));
				send_tick(pins);
				n++;
			end else begin
				target = PIN_W'($urandom_range(0, 3));
				noise = ($urandom_range(0, 9) < 4) ? $urandom_range(1, 4) : 0;
				repeat (noise) begin
					pins = PIN_W'($urandom_range(0, 3));
					send_tick(pins);
					n++;
				end
				hold = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
					: $urandom_range(1, 30);
				repeat (hold) begin
					send_tick(target);
					n++;
				end
			end
		end
	endtask

	initial begin
		int waited;
		int press;
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FILTER;
		cfg_data = '0;
		quiet = 1'b0;
		rx_stall = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_segments(150);

		wait_drained();
		write_reg(CFG_FILTER, 16'd1);
		write_reg(CFG_PRESS, 16'd2);
		write_reg(CFG_LONG_PRESS, 16'd4);
		write_reg(CFG_UNUSED, 16'hFFFF);
		foreach (DIRECTED[i])
			send_tick(DIRECTED[i]);

		wait_drained();
		write_reg(CFG_FILTER, 16'd0);
		write_reg(CFG_PRESS, 16'd0);
		write_reg(CFG_LONG_PRESS, 16'd0);
		run_segments(150);

		repeat (4) begin
			wait_drained();
			press = $urandom_range(0, 15);
			write_reg(CFG_FILTER, CNT_W'($urandom_range(0, 6)));
			write_reg(CFG_PRESS, CNT_W'(press));
			write_reg(CFG_LONG_PRESS, CNT_W'(press + $urandom_range(0, 40)));
			write_reg(CFG_UNUSED, CNT_W'($urandom_range(0, 65535)));
			run_segments(90);
			wait_drained();
			run_segments(90);
		end

		// Hold both buttons under the top thresholds, which the counters never reach here.
		wait_drained();
		write_reg(CFG_FILTER, 16'hFFFE);
		write_reg(CFG_PRESS, 16'hFFFF);
		write_reg(CFG_LONG_PRESS, 16'hFFFF);
		quiet = 1'b1;
		repeat (40) send_tick(BOTH_DOWN);
		repeat (8) send_tick(BOTH_UP);
		quiet = 1'b0;

		s_axis_tvalid <= 1'b0;
		waited = 0;
		@(negedge clk);
		while (pending != 0 && waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		repeat (4) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("button_debounce_press_classifier test passed");
		else
			$display("button_debounce_press_classifier test failed");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("button_debounce_press_classifier test failed");
		$finish;
	end
endmodule

[button_debounce_press_classifier.f]
+incdir+hdl
hdl/bdpc_pkg.sv
hdl/bdpc_lane.sv
hdl/bdpc_merge.sv
hdl/button_debounce_press_classifier.sv
sim/debounce_monitor.sv
sim/testbench.sv
